// File: src/lcc_pkg.sv
`timescale 1ns / 1ps

package lcc_pkg;

   localparam int GRID_SIZE = 16;
   localparam int GRID_W    = 4;
   localparam int CELL_W    = 12;
   localparam int ADDR_W    = 3 * GRID_W;
   localparam int CH_W      = 16;
   localparam int DIN_W     = CELL_W + 1;
   localparam int PROD_W    = CH_W + 1 + DIN_W;
   localparam int LED_MAX   = 255;

   localparam logic [3:0] SYM_ZERO = 4'b0001;
   localparam logic [3:0] SYM_ONE  = 4'b0111;

   localparam logic [1:0] CH_GREEN = 2'd0;
   localparam logic [1:0] CH_RED   = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   typedef logic [CH_W-1:0] chan_type;
   typedef logic [GRID_W-1:0] grid_type;

   typedef struct packed {
      chan_type          entry;
      chan_type          base;
      logic signed [DIN_W-1:0] d_in;
      logic              span_neg;
      logic              load;
   } mac_req_type;

   function automatic logic [31:0] encode_byte(input logic [7:0] v);
      logic [31:0] w;
      w = '0;
      for (int i = 0; i < 8; i++) begin
         w[4*i +: 4] = v[7-i] ? SYM_ONE : SYM_ZERO;
      end
      return w;
   endfunction

endpackage

// File: src/lcc_table.sv
`timescale 1ns / 1ps

module lcc_table (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [lcc_pkg::ADDR_W-1:0]    wr_addr,
   input  logic [3*lcc_pkg::CH_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [lcc_pkg::ADDR_W-1:0]    rd_addr,
   output logic [3*lcc_pkg::CH_W-1:0]    rd_data
);

   logic [3*lcc_pkg::CH_W-1:0] mem [0:(1 << lcc_pkg::ADDR_W)-1];
   logic [3*lcc_pkg::CH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lcc_mac.sv
`timescale 1ns / 1ps

module lcc_mac (
   input  logic                   clock,
   input  lcc_pkg::mac_req_type   req,
   output lcc_pkg::chan_type      corr
);

   logic signed [lcc_pkg::CH_W:0]     diff;
   logic signed [lcc_pkg::PROD_W-1:0] prod_in;
   logic signed [lcc_pkg::PROD_W-1:0] prod_ff;
   logic                              neg_span_ff;
   logic [lcc_pkg::PROD_W-1:0]        mag;
   logic [lcc_pkg::PROD_W-1:0]        qm;
   logic                              neg;

   assign diff    = $signed({1'b0, req.entry}) - $signed({1'b0, req.base});
   assign prod_in = diff * $signed(req.d_in);

   always_ff @(posedge clock) begin
      if (req.load) begin
         prod_ff     <= prod_in;
         neg_span_ff <= req.span_neg;
      end
   end

   // round half away from zero, divisor is +/- cell span
   assign mag  = prod_ff[lcc_pkg::PROD_W-1] ? lcc_pkg::PROD_W'(-prod_ff)
                                            : lcc_pkg::PROD_W'(prod_ff);
   assign qm   = (mag + lcc_pkg::PROD_W'(1 << (lcc_pkg::CELL_W - 1))) >> lcc_pkg::CELL_W;
   assign neg  = prod_ff[lcc_pkg::PROD_W-1] ^ neg_span_ff;
   assign corr = neg ? lcc_pkg::CH_W'(-qm[lcc_pkg::CH_W-1:0]) : qm[lcc_pkg::CH_W-1:0];

endmodule

// File: src/lut_color_correct_led_symbol_encoder_core.sv
`timescale 1ns / 1ps

// Load requests (op 0) write one 48-bit entry of the 16x16x16 correction table
// when accepted. A convert request (op 1) reads the reference entry and up to
// three neighbours through the table's single read port, runs up to nine
// multiply/round steps through one shared multiplier, then emits 3*LED_COUNT
// symbol words, one per cycle when the sink is ready. The table reads and the
// multiply/round steps run one after another on the single read port and the
// shared multiplier; req_ready is low from acceptance until the last word
// is loaded.
module lut_color_correct_led_symbol_encoder_core #(
   parameter int LED_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [11:0] req_table_index,
   input  logic [15:0] req_table_red,
   input  logic [15:0] req_table_green,
   input  logic [15:0] req_table_blue,
   input  logic [15:0] req_color_red,
   input  logic [15:0] req_color_green,
   input  logic [15:0] req_color_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_symbol_word,
   output logic [3:0]  rsp_led_index,
   output logic [1:0]  rsp_channel,
   output logic        rsp_last
);

   localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_RDB, S_BASE, S_AXIS, S_RDN, S_NBW, S_MUL, S_ACC, S_EMIT
   } state_type;

   state_type state_ff;

   lcc_pkg::grid_type ref_ff [0:2];
   lcc_pkg::grid_type nb_ff [0:2];
   logic signed [lcc_pkg::DIN_W-1:0] din_ff [0:2];
   logic [2:0] span_neg_ff;
   logic [2:0] span_zero_ff;
   logic [1:0] axis_ff;
   logic [1:0] ch_ff;
   lcc_pkg::chan_type base_ff [0:2];
   lcc_pkg::chan_type ent_ff [0:2];
   lcc_pkg::chan_type res_ff [0:2];
   logic [LED_W-1:0] led_ff;
   logic [1:0] och_ff;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] sym_ff;
   logic [3:0]  led_idx_ff;
   logic [1:0]  chan_ff;
   logic        last_ff;

   lcc_pkg::chan_type col [0:2];
   lcc_pkg::grid_type lo_c [0:2];
   lcc_pkg::grid_type ref_c [0:2];
   lcc_pkg::grid_type nb_c [0:2];
   logic signed [lcc_pkg::CH_W+1:0] din_c [0:2];

   logic accept;
   logic wr_en;
   logic rd_en;
   logic [lcc_pkg::ADDR_W-1:0] rd_addr;
   logic [3*lcc_pkg::CH_W-1:0] rd_data;
   lcc_pkg::grid_type pt [0:2];
   lcc_pkg::mac_req_type mac_req;
   lcc_pkg::chan_type corr;
   logic [1:0] src;
   lcc_pkg::chan_type rem_sel;
   logic [7:0] v;
   logic emit_go;
   logic is_last;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && (req_op == lcc_pkg::OP_LOAD);

   assign col[0] = req_color_red;
   assign col[1] = req_color_green;
   assign col[2] = req_color_blue;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lo_c[a] = col[a][lcc_pkg::CH_W-1 -: lcc_pkg::GRID_W];
         if (col[a][lcc_pkg::CELL_W-1] && (lo_c[a] != lcc_pkg::grid_type'(lcc_pkg::GRID_SIZE-1))) begin
            ref_c[a] = lo_c[a] + 1'b1;
         end else begin
            ref_c[a] = lo_c[a];
         end
         if (ref_c[a] == lo_c[a]) begin
            nb_c[a] = (ref_c[a] == lcc_pkg::grid_type'(lcc_pkg::GRID_SIZE-1)) ? ref_c[a]
                                                                             : ref_c[a] + 1'b1;
         end else begin
            nb_c[a] = ref_c[a] - 1'b1;
         end
         din_c[a] = $signed({2'b00, col[a]})
                  - $signed({2'b00, ref_c[a], {lcc_pkg::CELL_W{1'b0}}});
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pt[a] = ((state_ff == S_RDN) && (axis_ff == 2'(a))) ? nb_ff[a] : ref_ff[a];
      end
   end

   assign rd_en   = (state_ff == S_RDB) || (state_ff == S_RDN);
   assign rd_addr = {pt[1], pt[2], pt[0]};

   lcc_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_table_index),
      .wr_data ({req_table_blue, req_table_green, req_table_red}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mac_req.entry    = ent_ff[ch_ff];
   assign mac_req.base     = base_ff[ch_ff];
   assign mac_req.d_in     = din_ff[axis_ff];
   assign mac_req.span_neg = span_neg_ff[axis_ff];
   assign mac_req.load     = (state_ff == S_MUL);

   lcc_mac u_mac (
      .clock (clock),
      .req   (mac_req),
      .corr  (corr)
   );

   always_comb begin
      case (och_ff)
         lcc_pkg::CH_GREEN: src = 2'd1;
         lcc_pkg::CH_RED:   src = 2'd0;
         default:           src = 2'd2;
      endcase
   end

   assign rem_sel = res_ff[src];
   assign v       = (rem_sel < lcc_pkg::CH_W'(lcc_pkg::LED_MAX)) ? rem_sel[7:0] : 8'hFF;
   assign emit_go = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign is_last = (led_ff == LED_W'(LED_COUNT - 1)) && (och_ff == lcc_pkg::CH_BLUE);
   assign rsp_valid_in = emit_go || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= '0;
         ch_ff        <= '0;
         led_ff       <= '0;
         och_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (accept && (req_op == lcc_pkg::OP_CONVERT)) begin
                  for (int a = 0; a < 3; a++) begin
                     ref_ff[a]       <= ref_c[a];
                     nb_ff[a]        <= nb_c[a];
                     din_ff[a]       <= din_c[a][lcc_pkg::DIN_W-1:0];
                     span_neg_ff[a]  <= (nb_c[a] < ref_c[a]);
                     span_zero_ff[a] <= (nb_c[a] == ref_c[a]);
                  end
                  state_ff <= S_RDB;
               end
            end
            S_RDB: state_ff <= S_BASE;
            S_BASE: begin
               for (int c = 0; c < 3; c++) begin
                  base_ff[c] <= rd_data[c*lcc_pkg::CH_W +: lcc_pkg::CH_W];
                  res_ff[c]  <= rd_data[c*lcc_pkg::CH_W +: lcc_pkg::CH_W];
               end
               axis_ff  <= '0;
               state_ff <= S_AXIS;
            end
            S_AXIS: begin
               if (!span_zero_ff[axis_ff]) begin
                  state_ff <= S_RDN;
               end else if (axis_ff == 2'd2) begin
                  led_ff   <= '0;
                  och_ff   <= lcc_pkg::CH_GREEN;
                  state_ff <= S_EMIT;
               end else begin
                  axis_ff <= axis_ff + 2'd1;
               end
            end
            S_RDN: state_ff <= S_NBW;
            S_NBW: begin
               for (int c = 0; c < 3; c++) begin
                  ent_ff[c] <= rd_data[c*lcc_pkg::CH_W +: lcc_pkg::CH_W];
               end
               ch_ff    <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: state_ff <= S_ACC;
            S_ACC: begin
               res_ff[ch_ff] <= res_ff[ch_ff] + corr;
               if (ch_ff != 2'd2) begin
                  ch_ff    <= ch_ff + 2'd1;
                  state_ff <= S_MUL;
               end else if (axis_ff == 2'd2) begin
                  led_ff   <= '0;
                  och_ff   <= lcc_pkg::CH_GREEN;
                  state_ff <= S_EMIT;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_AXIS;
               end
            end
            S_EMIT: begin
               if (emit_go) begin
                  res_ff[src]  <= rem_sel - lcc_pkg::CH_W'(v);
                  sym_ff       <= lcc_pkg::encode_byte(v);
                  led_idx_ff   <= 4'(led_ff);
                  chan_ff      <= och_ff;
                  last_ff      <= is_last;
                  if (is_last) begin
                     state_ff <= S_IDLE;
                  end else if (och_ff == lcc_pkg::CH_BLUE) begin
                     och_ff <= lcc_pkg::CH_GREEN;
                     led_ff <= led_ff + 1'b1;
                  end else begin
                     och_ff <= och_ff + 2'd1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol_word = sym_ff;
   assign rsp_led_index   = led_idx_ff;
   assign rsp_channel     = chan_ff;
   assign rsp_last        = last_ff;

`ifndef NO_ASSERTIONS
   a_last_blue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_channel == lcc_pkg::CH_BLUE))
      else $error("last word not on blue channel");

   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> (ch_ff != 2'd3))
      else $error("channel counter out of range");

   a_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RDN) |-> (nb_ff[axis_ff] != ref_ff[axis_ff]))
      else $error("neighbour read on zero span axis");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int LEDS = 16;
   localparam int SPAN = 4096;

   typedef struct {
      logic        op;
      logic [11:0] idx;
      logic [15:0] tr, tg, tb;
      logic [15:0] cr, cg, cb;
   } request_type;

   typedef struct {
      logic [31:0] word;
      logic [3:0]  led;
      logic [1:0]  chan;
      logic        last;
   } symbol_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic req_op = 0;
   logic [11:0] req_table_index = 0;
   logic [15:0] req_table_red = 0, req_table_green = 0, req_table_blue = 0;
   logic [15:0] req_color_red = 0, req_color_green = 0, req_color_blue = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [31:0] rsp_symbol_word;
   logic [3:0] rsp_led_index;
   logic [1:0] rsp_channel;
   logic rsp_last;

   request_type pending[$];
   symbol_type  expected_symbols[$];
   request_type cur;
   bit busy = 0;
   int total_requests = 0;
   int sent_requests = 0;
   int errors = 0;
   bit calm;

   logic [15:0] lut_r[4096], lut_g[4096], lut_b[4096];
   bit planned[4096];

   lut_color_correct_led_symbol_encoder_core uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int lut_addr(int r, int g, int b);
      return (g * 16 + b) * 16 + r;
   endfunction

   function automatic void grid_points(input logic [15:0] c, output int rf, output int nb);
      int lo;
      lo = int'(c >> 12);
      rf = lo + ((c & 16'h0fff) >= SPAN / 2 ? 1 : 0);
      if (rf > lcc_pkg::GRID_SIZE - 1) rf = lcc_pkg::GRID_SIZE - 1;
      nb = (rf == lo) ? rf + 1 : rf - 1;
      if (nb < 0) nb = 0;
      if (nb > lcc_pkg::GRID_SIZE - 1) nb = lcc_pkg::GRID_SIZE - 1;
   endfunction

   function automatic longint round_half_away(longint n, longint d);
      longint an, ad, q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = (an + ad / 2) / ad;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic logic [31:0] symbols_of(logic [7:0] v);
      logic [31:0] w;
      w = '0;
      for (int i = 0; i < 8; i++)
         w[4*i +: 4] = v[7-i] ? lcc_pkg::SYM_ONE : lcc_pkg::SYM_ZERO;
      return w;
   endfunction

   task automatic predict_frame(request_type q);
      int rf[3], nb[3], pt[3];
      logic [15:0] col[3];
      longint base[3], ent[3], d_in, d_ref;
      logic [15:0] acc[3], left[3], v;
      int a0;
      symbol_type s;
      if (q.op == lcc_pkg::OP_LOAD) begin
         lut_r[q.idx] = q.tr;
         lut_g[q.idx] = q.tg;
         lut_b[q.idx] = q.tb;
         return;
      end
      col[0] = q.cr; col[1] = q.cg; col[2] = q.cb;
      for (int a = 0; a < 3; a++) grid_points(col[a], rf[a], nb[a]);
      a0 = lut_addr(rf[0], rf[1], rf[2]);
      base[0] = longint'(lut_r[a0]);
      base[1] = longint'(lut_g[a0]);
      base[2] = longint'(lut_b[a0]);
      for (int c = 0; c < 3; c++) acc[c] = 16'(base[c]);
      for (int a = 0; a < 3; a++) begin
         d_in = longint'(col[a]) - longint'(rf[a] * SPAN);
         d_ref = longint'((nb[a] - rf[a]) * SPAN);
         if (d_ref != 0) begin
            pt = rf;
            pt[a] = nb[a];
            a0 = lut_addr(pt[0], pt[1], pt[2]);
            ent[0] = longint'(lut_r[a0]);
            ent[1] = longint'(lut_g[a0]);
            ent[2] = longint'(lut_b[a0]);
            for (int c = 0; c < 3; c++)
               acc[c] = acc[c] + 16'(round_half_away((ent[c] - base[c]) * d_in, d_ref));
         end
      end
      left[0] = acc[1]; left[1] = acc[0]; left[2] = acc[2];
      for (int led = 0; led < LEDS; led++) begin
         for (int c = 0; c < 3; c++) begin
            v = left[c] < 16'(lcc_pkg::LED_MAX) ? left[c] : 16'(lcc_pkg::LED_MAX);
            left[c] -= v;
            s.word = symbols_of(v[7:0]);
            s.led = led[3:0];
            s.chan = c[1:0];
            s.last = (led == LEDS - 1 && c == 2);
            expected_symbols.push_back(s);
         end
      end
   endtask

   task automatic add_load(int idx, logic [15:0] r, logic [15:0] g, logic [15:0] b);
      request_type q;
      q = '{lcc_pkg::OP_LOAD, idx[11:0], r, g, b, 16'd0, 16'd0, 16'd0};
      q.cr = 16'($urandom); q.cg = 16'($urandom); q.cb = 16'($urandom);
      planned[idx] = 1;
      pending.push_back(q);
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'($urandom_range(4095));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_color(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      request_type q;
      int rf[3], nb[3], pt[3], ad;
      grid_points(r, rf[0], nb[0]);
      grid_points(g, rf[1], nb[1]);
      grid_points(b, rf[2], nb[2]);
      for (int a = -1; a < 3; a++) begin
         pt = rf;
         if (a >= 0) pt[a] = nb[a];
         ad = lut_addr(pt[0], pt[1], pt[2]);
         if (!planned[ad]) add_load(ad, pick16(), pick16(), pick16());
      end
      q = '{lcc_pkg::OP_CONVERT, 12'($urandom), pick16(), pick16(), pick16(), r, g, b};
      pending.push_back(q);
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_frame(cur);
         sent_requests++;
         busy = 0;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_symbols.size() == 0) begin
            $display("%0t: unexpected symbol word %h led %0d chan %0d last %0d", $time,
                     rsp_symbol_word, rsp_led_index, rsp_channel, rsp_last);
            errors++;
         end else begin
            symbol_type e;
            e = expected_symbols.pop_front();
            if (rsp_symbol_word !== e.word || rsp_led_index !== e.led ||
                rsp_channel !== e.chan || rsp_last !== e.last) begin
               $display("%0t: expected word %h led %0d chan %0d last %0d, got %h %0d %0d %0d",
                        $time, e.word, e.led, e.chan, e.last, rsp_symbol_word,
                        rsp_led_index, rsp_channel, rsp_last);
               errors++;
            end
         end
      end
   end

   assign calm = sent_requests >= 150 && sent_requests < 230;

   always @(negedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(99) >= 13);
      if (!reset && !busy) begin
         if (pending.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
            cur = pending.pop_front();
            req_op <= cur.op;
            req_table_index <= cur.idx;
            req_table_red <= cur.tr;
            req_table_green <= cur.tg;
            req_table_blue <= cur.tb;
            req_color_red <= cur.cr;
            req_color_green <= cur.cg;
            req_color_blue <= cur.cb;
            req_valid <= 1;
            busy = 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [15:0] edges[6];
      edges = '{16'h0000, 16'hffff, 16'h0800, 16'h07ff, 16'hf800, 16'h8800};
      for (int i = 0; i < 4096; i++) planned[i] = 0;
      // corners with extreme contents, then edge colors
      add_load(lut_addr(0, 0, 0), 16'hffff, 16'hffff, 16'hffff);
      add_load(lut_addr(15, 15, 15), 16'h0000, 16'h0000, 16'h0000);
      add_load(lut_addr(1, 0, 0), 16'h0000, 16'hffff, 16'h1234);
      add_load(lut_addr(0, 1, 0), 16'h8000, 16'h0001, 16'hfffe);
      add_load(lut_addr(0, 0, 1), 16'h0fff, 16'h00ff, 16'h0100);
      for (int i = 0; i < 6; i++) add_color(edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6]);
      add_color(16'h0000, 16'h0000, 16'h0000);
      add_color(16'hffff, 16'hffff, 16'hffff);
      add_load(lut_addr(0, 0, 0), 16'h0fef, 16'h0ff0, 16'h0ff1);
      add_color(16'h0000, 16'h0000, 16'h0000);
      while (pending.size() < 380) begin
         if ($urandom_range(3) == 0)
            add_load($urandom_range(4095), pick16(), pick16(), pick16());
         else if ($urandom_range(2) == 0)
            add_color(edges[$urandom_range(5)], pick16(), pick16());
         else
            add_color(16'($urandom), 16'($urandom), 16'($urandom));
      end
      total_requests = pending.size();
      repeat (9) @(negedge clock);
      reset = 0;
      while (sent_requests < total_requests || expected_symbols.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_symbols.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
